@@ rtl/byte_lifo_stack_core_assert.svh @@
// ----------------------------------------------------------------------------
// Byte LIFO stack assertion macros
// Property wrappers shared by the stack RTL; clocked, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BYTE_LIFO_STACK_CORE_ASSERT_SVH
`define BYTE_LIFO_STACK_CORE_ASSERT_SVH

// same-cycle implication
`define BLS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bls assertion failed");

// next-cycle implication
`define BLS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bls assertion failed");

`endif

@@ rtl/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// Byte LIFO stack package
// Field widths, operation and status codes, sequencer states, defaults.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int MAX_BYTES_DEF = 8;

    localparam int CAP_W   = 11;
    localparam int COUNT_W = 4;
    localparam int DATA_W  = 64;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;

    // s_tdata: byte_count, push_data, zero pad to bytes
    localparam int S_TDATA_W = 72;
    // m_tdata: pop_data, space_left, is_full, is_empty, zero pad to bytes
    localparam int M_TDATA_W = 80;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_SHORT   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_DRAIN,
        S_FINISH
    } state_t;

endpackage

@@ rtl/bls_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, written when we is high and always read; read data registered.
// ----------------------------------------------------------------------------
module bls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bls_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/byte_lifo_stack_core.sv @@
// ----------------------------------------------------------------------------
// Byte LIFO stack core
// Byte-addressed stack in a byte-wide RAM, moved one byte per cycle.
// ----------------------------------------------------------------------------
// An accepted push writes its bytes in S_PUSH; a pop reads them in S_POP and gets
// the last registered byte in S_DRAIN; every command then ends in S_FINISH, which
// loads the result register when the result side is free. Items are taken one at
// a time, only in S_IDLE; the single byte-wide RAM port moves one byte per cycle.
// Reset (aresetn low, synchronous): stack empty, capacity DEPTH, no result held.
// RAM contents are not cleared; bytes are read only after they were pushed.
// ----------------------------------------------------------------------------
`include "byte_lifo_stack_core_assert.svh"

module byte_lifo_stack_core #(
    parameter int DEPTH     = bls_pkg::DEPTH_DEF,
    parameter int MAX_BYTES = bls_pkg::MAX_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // capacity register write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bls_pkg::CAP_W-1:0]      cfg_data,     // capacity_bytes

    // command stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bls_pkg::S_TDATA_W-1:0]  s_tdata,      // [3:0] byte_count, [67:4] push_data
    input  logic [bls_pkg::FUNC_W-1:0]     s_tuser,      // [1:0] func

    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bls_pkg::M_TDATA_W-1:0]  m_tdata,      // [63:0] pop_data, [74:64] space_left,
                                                         // [75] is_full, [76] is_empty
    output logic [bls_pkg::STAT_W-1:0]     m_tuser       // [1:0] status
);

    // top and capacity hold 0..DEPTH; RAM address holds 0..DEPTH-1
    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // byte index within one transfer
    localparam int IW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    // ------------------------------------------------------------------------
    // Input field unpack
    // ------------------------------------------------------------------------
    logic [bls_pkg::FUNC_W-1:0]  in_func;
    logic [bls_pkg::COUNT_W-1:0] in_count;
    logic [bls_pkg::DATA_W-1:0]  in_data;

    assign in_func  = s_tuser;
    assign in_count = s_tdata[bls_pkg::COUNT_W-1:0];
    assign in_data  = s_tdata[bls_pkg::COUNT_W +: bls_pkg::DATA_W];

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    bls_pkg::state_t state_reg, state_next;

    logic [PW-1:0]  top_reg,  top_next;      // stack top (bytes held)
    logic [PW-1:0]  cap_reg,  cap_next;      // capacity in use
    logic [PW-1:0]  base_reg;                // first address of this transfer
    logic [IW-1:0]  idx_reg;                 // byte sequencer
    logic [IW-1:0]  last_reg;                // byte_count - 1
    logic           rd_valid_reg;            // RAM read data arrives this cycle
    logic [IW-1:0]  rd_lane_reg;             // lane of that data

    logic [bls_pkg::DATA_W-1:0]  push_data_reg;
    logic [bls_pkg::DATA_W-1:0]  pop_data_reg;
    logic [bls_pkg::STAT_W-1:0]  stat_reg;

    // output register
    logic                        m_valid_reg;
    logic [bls_pkg::STAT_W-1:0]  m_stat_reg;
    logic [bls_pkg::DATA_W-1:0]  m_pop_reg;
    logic [bls_pkg::CAP_W-1:0]   m_space_reg;
    logic                        m_full_reg;
    logic                        m_empty_reg;

    logic s_xfer;
    logic cfg_xfer;
    logic out_free;
    logic seq_last;
    logic ram_we;

    assign s_xfer   = s_tvalid && s_tready;
    assign cfg_xfer = cfg_valid && cfg_ready;
    assign out_free = !m_valid_reg || m_tready;
    assign seq_last = (idx_reg == last_reg);

    // ------------------------------------------------------------------------
    // Command decode at the accepting edge: status and new top
    // ------------------------------------------------------------------------
    logic                       size_ok;
    logic [PW-1:0]              count_ext;
    logic [PW-1:0]              space_now;
    logic [bls_pkg::STAT_W-1:0] dec_stat;
    logic [PW-1:0]              dec_top;
    logic [PW-1:0]              dec_base;

    assign size_ok   = (in_count != '0) && (32'(in_count) <= 32'(MAX_BYTES));
    assign count_ext = PW'(in_count);
    assign space_now = cap_reg - top_reg;

    always_comb begin
        dec_stat = bls_pkg::ST_OK;
        dec_top  = top_reg;
        dec_base = top_reg;
        case (in_func)
            bls_pkg::FUNC_PUSH: begin
                if (!size_ok) begin
                    dec_stat = bls_pkg::ST_INVALID;
                end else if (32'(space_now) < 32'(in_count)) begin
                    dec_stat = bls_pkg::ST_SHORT;
                end else begin
                    dec_top = top_reg + count_ext;
                end
            end
            bls_pkg::FUNC_POP: begin
                if (!size_ok) begin
                    dec_stat = bls_pkg::ST_INVALID;
                end else if (top_reg == '0) begin
                    dec_stat = bls_pkg::ST_EMPTY;
                end else if (32'(top_reg) < 32'(in_count)) begin
                    dec_stat = bls_pkg::ST_SHORT;
                end else begin
                    dec_top  = top_reg - count_ext;
                    dec_base = top_reg - count_ext;
                end
            end
            bls_pkg::FUNC_CLEAR: begin
                dec_top = '0;
            end
            default: begin
                dec_stat = bls_pkg::ST_INVALID;
            end
        endcase
    end

    // capacity write saturates at DEPTH and empties the stack
    always_comb begin
        cap_next = cap_reg;
        top_next = top_reg;
        if (cfg_xfer) begin
            if (32'(cfg_data) > 32'(DEPTH)) begin
                cap_next = PW'(DEPTH);
            end else begin
                cap_next = PW'(cfg_data);
            end
            top_next = '0;
        end else if (s_xfer) begin
            top_next = dec_top;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bls_pkg::S_IDLE: begin
                if (s_xfer) begin
                    if (dec_stat != bls_pkg::ST_OK) begin
                        state_next = bls_pkg::S_FINISH;
                    end else if (in_func == bls_pkg::FUNC_PUSH) begin
                        state_next = bls_pkg::S_PUSH;
                    end else if (in_func == bls_pkg::FUNC_POP) begin
                        state_next = bls_pkg::S_POP;
                    end else begin
                        state_next = bls_pkg::S_FINISH;
                    end
                end
            end
            bls_pkg::S_PUSH: begin
                if (seq_last) begin
                    state_next = bls_pkg::S_FINISH;
                end
            end
            bls_pkg::S_POP: begin
                if (seq_last) begin
                    state_next = bls_pkg::S_DRAIN;
                end
            end
            bls_pkg::S_DRAIN: begin
                state_next = bls_pkg::S_FINISH;
            end
            bls_pkg::S_FINISH: begin
                if (out_free) begin
                    state_next = bls_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bls_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------------
    always_comb begin
        cfg_ready = 1'b0;
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        unique case (state_reg)
            bls_pkg::S_IDLE: begin
                cfg_ready = 1'b1;
                // a capacity write wins over a command in the same cycle
                s_tready  = !cfg_valid;
            end
            bls_pkg::S_PUSH: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Shared address adder and byte RAM
    // ------------------------------------------------------------------------
    logic [PW-1:0] addr_sum;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign addr_sum  = base_reg + PW'(idx_reg);
    assign ram_wdata = push_data_reg[8*idx_reg +: 8];

    bls_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (addr_sum[AW-1:0]),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bls_pkg::S_IDLE;
            top_reg      <= '0;
            cap_reg      <= PW'(DEPTH);
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            cap_reg      <= cap_next;
            rd_valid_reg <= (state_reg == bls_pkg::S_POP);
            if (s_xfer) begin
                idx_reg <= '0;
            end else if (state_reg == bls_pkg::S_PUSH || state_reg == bls_pkg::S_POP) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (state_reg == bls_pkg::S_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        rd_lane_reg <= idx_reg;
        if (s_xfer) begin
            base_reg      <= dec_base;
            last_reg      <= IW'(in_count - 1'b1);
            push_data_reg <= in_data;
            pop_data_reg  <= '0;
            stat_reg      <= dec_stat;
        end else if (rd_valid_reg) begin
            pop_data_reg[8*rd_lane_reg +: 8] <= ram_rdata;
        end
        if (state_reg == bls_pkg::S_FINISH && out_free) begin
            m_stat_reg  <= stat_reg;
            m_pop_reg   <= pop_data_reg;
            m_space_reg <= bls_pkg::CAP_W'(cap_reg - top_reg);
            m_full_reg  <= (top_reg >= cap_reg);
            m_empty_reg <= (top_reg == '0);
        end
    end

    // ------------------------------------------------------------------------
    // Result pack
    // ------------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tdata  = {3'b000, m_empty_reg, m_full_reg, m_space_reg, m_pop_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `BLS_ASSERT_NOW(a_top_within_cap, aclk, aresetn, 1'b1, top_reg <= cap_reg)
    `BLS_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_xfer, state_reg != bls_pkg::S_IDLE)
    `BLS_ASSERT_NOW(a_idx_in_range, aclk, aresetn,
        state_reg == bls_pkg::S_PUSH || state_reg == bls_pkg::S_POP, idx_reg <= last_reg)
    `BLS_ASSERT_NOW(a_fail_no_data, aclk, aresetn,
        m_valid_reg && m_stat_reg != bls_pkg::ST_OK, m_pop_reg == '0)

endmodule
